// ----- hdl/tad_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tad_pkg
// Shared types and constants of the track action debouncer.
// ----------------------------------------------------------------------------
package tad_pkg;

    localparam int ENTRIES = 64;
    localparam int IDX_W   = $clog2(ENTRIES);

    localparam logic [1:0] OP_OBSERVE = 2'd0;
    localparam logic [1:0] OP_SWEEP   = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;

    localparam logic [1:0] REG_CONFIRM  = 2'd0;
    localparam logic [1:0] REG_RELEASE  = 2'd1;
    localparam logic [1:0] REG_COOLDOWN = 2'd2;
    localparam logic [1:0] REG_STALE    = 2'd3;

    localparam logic [2:0]  LABEL_FALL     = 3'd1;
    localparam logic [1:0]  SEV_FALL       = 2'd3;
    localparam logic [1:0]  SEV_OTHER      = 2'd2;
    localparam logic [31:0] STALE_RESET    = 32'd120000;
    localparam logic [31:0] COOLDOWN_RESET = 32'd5000;
    localparam logic [7:0]  COUNT_RESET    = 8'd3;
    localparam logic [7:0]  HITS_MAX       = 8'd255;
    localparam logic [6:0]  EVICT_MAX      = 7'd127;

    typedef struct packed {
        logic [31:0] track;
        logic [2:0]  label;
        logic        active;
        logic [7:0]  confirm_hits;
        logic [7:0]  rel_hits;
        logic [15:0] last_conf;
        logic [47:0] start_time;
        logic [47:0] last_end;
        logic        ended;
        logic [47:0] last_seen;
    } entry_t;

    typedef struct packed {
        logic        has_event;
        logic        is_end;
        logic [31:0] event_track;
        logic [2:0]  event_label;
        logic [31:0] event_number;
        logic [47:0] onset_ms;
        logic [47:0] stamp_ms;
        logic [15:0] event_confidence;
        logic [1:0]  severity;
        logic        dropped;
        logic [6:0]  evicted_count;
    } result_t;

    typedef struct packed {
        logic capture;
        logic idx_inc;
        logic rd_en;
        logic obs_cmp;
        logic swp_eval;
        logic update;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       match;
        logic       idx_last;
        logic       out_free;
    } stat_t;

endpackage

// ----- hdl/tad_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tad_ctrl
// Sequencer that walks the entry table and hands results to the output.
// ----------------------------------------------------------------------------
module tad_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  tad_pkg::stat_t stat,
    output tad_pkg::cmd_t  cmd
);
    import tad_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_CMP  = 3'd2;
    localparam logic [2:0] ST_UPD  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_RD;
                end
            end
            ST_RD: begin
                if (stat.op == OP_OBSERVE || stat.op == OP_SWEEP) begin
                    cmd.rd_en  = 1'b1;
                    state_next = ST_CMP;
                end else begin
                    state_next = ST_UPD;
                end
            end
            ST_CMP: begin
                if (stat.op == OP_OBSERVE) begin
                    cmd.obs_cmp = 1'b1;
                end else begin
                    cmd.swp_eval = 1'b1;
                end
                if ((stat.op == OP_OBSERVE && stat.match) || stat.idx_last) begin
                    state_next = ST_UPD;
                end else begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_RD;
                end
            end
            ST_UPD: begin
                if (stat.out_free) begin
                    cmd.update = 1'b1;
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                cmd.out_load = 1'b1;
                state_next   = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- hdl/tad_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tad_datapath
// Entry table, configuration registers, debounce update and result register.
// ----------------------------------------------------------------------------
module tad_datapath (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [31:0]      cfg_data,
    input  logic [1:0]       s_opcode,
    input  logic [31:0]      s_track,
    input  logic [2:0]       s_label,
    input  logic             s_positive,
    input  logic [15:0]      s_confidence,
    input  logic [47:0]      s_frame_ms,
    input  tad_pkg::cmd_t    cmd,
    output tad_pkg::stat_t   stat,
    input  logic             m_ready,
    output logic             m_valid,
    output tad_pkg::result_t m_result
);
    import tad_pkg::*;

    logic [7:0]  confirm_reg;
    logic [7:0]  release_reg;
    logic [31:0] cooldown_reg;
    logic [31:0] stale_reg;

    logic [1:0]  op_reg;
    logic [31:0] trk_reg;
    logic [2:0]  lab_reg;
    logic        pos_reg;
    logic [15:0] conf_reg;
    logic [47:0] now_reg;

    logic [IDX_W-1:0]   idx_reg;
    logic               hit_reg;
    logic [IDX_W-1:0]   slot_reg;
    logic               free_found_reg;
    logic [IDX_W-1:0]   free_idx_reg;
    logic [6:0]         evict_reg;
    logic [ENTRIES-1:0] valid_reg;
    logic [31:0]        counter_reg;
    entry_t             rdata_reg;
    result_t            res_reg;
    result_t            res_next;
    logic               m_valid_reg;

    entry_t entry_mem [ENTRIES];

    logic             match;
    logic             stale_hit;
    logic [47:0]      seen_diff;
    entry_t           e_cur;
    entry_t           e_new;
    logic [IDX_W-1:0] wr_slot;
    logic             wr_en;
    logic             cooled;
    logic [47:0]      end_diff;
    logic [7:0]       ch_inc;
    logic [7:0]       rh_inc;
    logic             emit;

    assign match = valid_reg[idx_reg] && rdata_reg.track == trk_reg
                   && rdata_reg.label == lab_reg;
    assign seen_diff = now_reg - rdata_reg.last_seen;
    assign stale_hit = valid_reg[idx_reg] && now_reg > rdata_reg.last_seen
                       && seen_diff > {16'd0, stale_reg};

    assign stat.op       = op_reg;
    assign stat.match    = match;
    assign stat.idx_last = (idx_reg == IDX_W'(ENTRIES - 1));
    assign stat.out_free = !m_valid_reg || m_ready;

    assign m_valid  = m_valid_reg;
    assign m_result = res_reg;

    always_comb begin
        e_cur = '0;
        if (hit_reg) begin
            e_cur = rdata_reg;
        end else begin
            e_cur.track = trk_reg;
            e_cur.label = lab_reg;
        end
        wr_slot  = hit_reg ? slot_reg : free_idx_reg;
        wr_en    = cmd.update && op_reg == OP_OBSERVE && (hit_reg || free_found_reg);
        end_diff = now_reg - e_cur.last_end;
        cooled   = !e_cur.ended || (now_reg >= e_cur.last_end
                   && end_diff >= {16'd0, cooldown_reg});
        ch_inc   = (e_cur.confirm_hits < HITS_MAX) ? e_cur.confirm_hits + 8'd1
                                                   : e_cur.confirm_hits;
        rh_inc   = (e_cur.rel_hits < HITS_MAX) ? e_cur.rel_hits + 8'd1
                                               : e_cur.rel_hits;
        e_new           = e_cur;
        e_new.last_seen = now_reg;
        res_next        = '0;
        emit            = 1'b0;
        if (pos_reg) begin
            e_new.rel_hits  = 8'd0;
            e_new.last_conf = conf_reg;
            if (!e_cur.active && cooled) begin
                e_new.confirm_hits = ch_inc;
                if (ch_inc >= confirm_reg) begin
                    e_new.active       = 1'b1;
                    e_new.start_time   = now_reg;
                    e_new.confirm_hits = 8'd0;
                    emit                      = 1'b1;
                    res_next.is_end           = 1'b0;
                    res_next.onset_ms         = now_reg;
                    res_next.event_confidence = conf_reg;
                end
            end
        end else begin
            e_new.confirm_hits = 8'd0;
            if (e_cur.active) begin
                e_new.rel_hits = rh_inc;
                if (rh_inc >= release_reg) begin
                    e_new.active   = 1'b0;
                    e_new.rel_hits = 8'd0;
                    e_new.last_end = now_reg;
                    e_new.ended    = 1'b1;
                    emit                      = 1'b1;
                    res_next.is_end           = 1'b1;
                    res_next.onset_ms         = e_cur.start_time;
                    res_next.event_confidence = e_cur.last_conf;
                end
            end
        end
        if (emit) begin
            res_next.has_event    = 1'b1;
            res_next.event_track  = trk_reg;
            res_next.event_label  = lab_reg;
            res_next.event_number = counter_reg;
            res_next.stamp_ms     = now_reg;
            res_next.severity     = (lab_reg == LABEL_FALL) ? SEV_FALL : SEV_OTHER;
        end
        if (op_reg == OP_OBSERVE && !wr_en) begin
            res_next         = '0;
            res_next.dropped = 1'b1;
        end else if (op_reg == OP_SWEEP) begin
            res_next               = '0;
            res_next.evicted_count = evict_reg;
        end else if (op_reg != OP_OBSERVE) begin
            res_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            rdata_reg <= entry_mem[idx_reg];
        end
        if (wr_en) begin
            entry_mem[wr_slot] <= e_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg   <= s_opcode;
            trk_reg  <= s_track;
            lab_reg  <= s_label;
            pos_reg  <= s_positive;
            conf_reg <= s_confidence;
            now_reg  <= s_frame_ms;
        end
        if (cmd.update) begin
            res_reg <= res_next;
        end
        if (cmd.obs_cmp && match && !hit_reg) begin
            slot_reg <= idx_reg;
        end
        if (cmd.obs_cmp && !valid_reg[idx_reg] && !free_found_reg) begin
            free_idx_reg <= idx_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            confirm_reg    <= COUNT_RESET;
            release_reg    <= COUNT_RESET;
            cooldown_reg   <= COOLDOWN_RESET;
            stale_reg      <= STALE_RESET;
            valid_reg      <= '0;
            counter_reg    <= '0;
            m_valid_reg    <= 1'b0;
            idx_reg        <= '0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            evict_reg      <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_CONFIRM:  confirm_reg  <= cfg_data[7:0];
                    REG_RELEASE:  release_reg  <= cfg_data[7:0];
                    REG_COOLDOWN: cooldown_reg <= cfg_data;
                    REG_STALE:    stale_reg    <= cfg_data;
                    default:      confirm_reg  <= confirm_reg;
                endcase
            end
            if (cmd.capture) begin
                idx_reg        <= '0;
                hit_reg        <= 1'b0;
                free_found_reg <= 1'b0;
                evict_reg      <= '0;
            end
            if (cmd.idx_inc) begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.obs_cmp) begin
                if (match) begin
                    hit_reg <= 1'b1;
                end
                if (!valid_reg[idx_reg]) begin
                    free_found_reg <= 1'b1;
                end
            end
            if (cmd.swp_eval && stale_hit) begin
                valid_reg[idx_reg] <= 1'b0;
                if (evict_reg < EVICT_MAX) begin
                    evict_reg <= evict_reg + 7'd1;
                end
            end
            if (cmd.update) begin
                if (op_reg == OP_CLEAR) begin
                    valid_reg <= '0;
                end else if (wr_en) begin
                    valid_reg[wr_slot] <= 1'b1;
                end
                if (wr_en && emit) begin
                    counter_reg <= counter_reg + 32'd1;
                end
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ----- hdl/track_action_debouncer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// track_action_debouncer
// Debounces per-track action detections into start and end events.
// ----------------------------------------------------------------------------
// An observe that hits entry k ends its table walk there; a miss, a full table
// or a sweep walks all entries, and a clear or unused opcode walks none. One
// item is in work at a time and the next is accepted in the same cycle as the
// word appears; the table walk through the registered memory read sets the
// rate. A word not yet taken holds the next item before its table update.
// Reset clears the valid bits, event counter and control registers and loads
// the configuration register defaults.
module track_action_debouncer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [31:0] s_track,
    input  logic [2:0]  s_label,
    input  logic        s_positive,
    input  logic [15:0] s_confidence,
    input  logic [47:0] s_frame_ms,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_has_event,
    output logic        m_is_end,
    output logic [31:0] m_event_track,
    output logic [2:0]  m_event_label,
    output logic [31:0] m_event_number,
    output logic [47:0] m_onset_ms,
    output logic [47:0] m_stamp_ms,
    output logic [15:0] m_event_confidence,
    output logic [1:0]  m_severity,
    output logic        m_dropped,
    output logic [6:0]  m_evicted_count
);
    import tad_pkg::*;

    cmd_t    cmd;
    stat_t   stat;
    result_t res;

    tad_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    tad_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_opcode     (s_opcode),
        .s_track      (s_track),
        .s_label      (s_label),
        .s_positive   (s_positive),
        .s_confidence (s_confidence),
        .s_frame_ms   (s_frame_ms),
        .cmd          (cmd),
        .stat         (stat),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_result     (res)
    );

    assign m_has_event        = res.has_event;
    assign m_is_end           = res.is_end;
    assign m_event_track      = res.event_track;
    assign m_event_label      = res.event_label;
    assign m_event_number     = res.event_number;
    assign m_onset_ms         = res.onset_ms;
    assign m_stamp_ms         = res.stamp_ms;
    assign m_event_confidence = res.event_confidence;
    assign m_severity         = res.severity;
    assign m_dropped          = res.dropped;
    assign m_evicted_count    = res.evicted_count;

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while an item is in work");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid || m_ready))
        else $error("result word overwritten before it was taken");

    a_event_only_observe: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_has_event) |-> (!m_dropped && m_evicted_count == 7'd0))
        else $error("event word carries drop or eviction status");

endmodule
